FILE: hw/rtl/mec_pkg.sv
// shared constants and types for the multiset equality checker
package mec_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int IN_ELEM_W         = 32;
  localparam int OPCODE_W          = 2;

  localparam logic [OPCODE_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPARE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/multiset_equality_check_top.sv
// multiset equality checker: two element stores and a sequenced pairwise matcher
// loads are taken while idle; a compare decided at once (overflow, unequal counts,
// both empty) goes straight to the finish state, otherwise the matcher
// tests one (a, b) pair per cycle through the single comparator, and the
// finish state then writes the result to the output register; in_ready stays low
// until the result is in the output register, which waits while out_ready holds off
// synchronous active-low reset clears counts, overflow flag, match marks and
// output valid; store contents stay undefined until written
module multiset_equality_check_top #(
  parameter int CAPACITY      = mec_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = mec_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mec_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic signed [mec_pkg::IN_ELEM_W-1:0] in_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_same_elements,
  output logic                            out_overflowed
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EXT_W = 64;

  mec_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]       count_a_r, count_a_nxt;
  logic [CW-1:0]       count_b_r, count_b_nxt;
  logic                ovf_r, ovf_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic [CAPACITY-1:0] mark_r, mark_nxt;
  logic                same_r, same_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_same_r, out_same_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic [ELEMENT_WIDTH-1:0] mem_a [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] mem_b [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] a_rdata_r;
  logic [ELEMENT_WIDTH-1:0] b_rdata_r;

  logic [EXT_W-1:0]         elem_ext;
  logic [ELEMENT_WIDTH-1:0] elem_val;
  logic                     in_acc;
  logic                     wr_a;
  logic                     wr_b;
  logic                     hit;
  logic                     last_i;
  logic                     last_j;

  // sign-extend the request element, then keep the configured width
  assign elem_ext = {{(EXT_W - mec_pkg::IN_ELEM_W){in_element[mec_pkg::IN_ELEM_W-1]}},
                     in_element};
  assign elem_val = elem_ext[ELEMENT_WIDTH-1:0];

  assign in_ready = (state_r == mec_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_a     = in_acc && (in_opcode == mec_pkg::OP_LOAD_A) &&
                    (count_a_r < CW'(CAPACITY));
  assign wr_b     = in_acc && (in_opcode == mec_pkg::OP_LOAD_B) &&
                    (count_b_r < CW'(CAPACITY));

  assign hit    = !mark_r[j_r] && (a_rdata_r == b_rdata_r);
  assign last_i = (CW'(i_r) + CW'(1)) == count_a_r;
  assign last_j = (CW'(j_r) + CW'(1)) == count_b_r;

  assign out_valid         = out_valid_r;
  assign out_same_elements = out_same_r;
  assign out_overflowed    = out_ovf_r;

  // element stores, read addresses follow the next scan position
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a_r[IW-1:0]] <= elem_val;
    end
    if (wr_b) begin
      mem_b[count_b_r[IW-1:0]] <= elem_val;
    end
    a_rdata_r <= mem_a[i_nxt];
    b_rdata_r <= mem_b[j_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mec_pkg::ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      mark_r      <= '0;
      same_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      mark_r      <= mark_nxt;
      same_r      <= same_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_same_r <= out_same_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_a_nxt   = count_a_r;
    count_b_nxt   = count_b_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mark_nxt      = mark_r;
    same_nxt      = same_r;
    out_valid_nxt = out_valid_r;
    out_same_nxt  = out_same_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mec_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            mec_pkg::OP_LOAD_A: begin
              if (wr_a) begin
                count_a_nxt = count_a_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            mec_pkg::OP_LOAD_B: begin
              if (wr_b) begin
                count_b_nxt = count_b_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            mec_pkg::OP_COMPARE: begin
              mark_nxt = '0;
              i_nxt    = '0;
              j_nxt    = '0;
              if (ovf_r || (count_a_r != count_b_r)) begin
                same_nxt  = 1'b0;
                state_nxt = mec_pkg::ST_FINISH;
              end else if (count_a_r == '0) begin
                same_nxt  = 1'b1;
                state_nxt = mec_pkg::ST_FINISH;
              end else begin
                state_nxt = mec_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      mec_pkg::ST_SCAN: begin
        if (hit) begin
          mark_nxt[j_r] = 1'b1;
          if (last_i) begin
            same_nxt  = 1'b1;
            state_nxt = mec_pkg::ST_FINISH;
          end else begin
            i_nxt = i_r + IW'(1);
            j_nxt = '0;
          end
        end else if (last_j) begin
          same_nxt  = 1'b0;
          state_nxt = mec_pkg::ST_FINISH;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end

      mec_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_same_nxt  = same_r;
          out_ovf_nxt   = ovf_r;
          count_a_nxt   = '0;
          count_b_nxt   = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = mec_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mec_pkg::ST_IDLE;
      end
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mec_pkg::ST_IDLE) |-> !in_ready)
    else $error("request taken while compare in progress");

  a_marks_track_a: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mec_pkg::ST_SCAN) |-> ($countones(mark_r) == int'(i_r)))
    else $error("match marks out of step with a index");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CW'(CAPACITY)) && (count_b_r <= CW'(CAPACITY)))
    else $error("element count beyond capacity");

  a_ovf_not_same: assert property (@(posedge clk) disable iff (!rst_n)
    (state_nxt == mec_pkg::ST_IDLE && state_r == mec_pkg::ST_FINISH) |=>
      !(out_same_r && out_ovf_r))
    else $error("overflowed compare reported equal");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for the multiset equality checker with a scoreboard class and request drivers

class multiset_scoreboard;
  logic [31:0] elems_a [mec_pkg::CAPACITY_DEF];
  logic [31:0] elems_b [mec_pkg::CAPACITY_DEF];
  int unsigned fill_a;
  int unsigned fill_b;
  bit          lost_load;
  bit          want_same [$];
  bit          want_ovf [$];
  int          errors;

  function new();
    fill_a    = 0;
    fill_b    = 0;
    lost_load = 1'b0;
    errors    = 0;
  endfunction

  // walk a in order, each element claims the first unclaimed equal b element
  function bit multisets_match();
    bit claimed [mec_pkg::CAPACITY_DEF];
    bit found;
    foreach (claimed[k]) claimed[k] = 1'b0;
    if (lost_load || fill_a != fill_b) return 1'b0;
    for (int i = 0; i < fill_a; i++) begin
      found = 1'b0;
      for (int j = 0; j < fill_b && !found; j++) begin
        if (!claimed[j] && elems_a[i] == elems_b[j]) begin
          claimed[j] = 1'b1;
          found     = 1'b1;
        end
      end
      if (!found) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_request(logic [1:0] opcode, logic [31:0] element);
    case (opcode)
      mec_pkg::OP_LOAD_A: begin
        if (fill_a < mec_pkg::CAPACITY_DEF) begin
          elems_a[fill_a] = element;
          fill_a++;
        end else begin
          lost_load = 1'b1;
        end
      end
      mec_pkg::OP_LOAD_B: begin
        if (fill_b < mec_pkg::CAPACITY_DEF) begin
          elems_b[fill_b] = element;
          fill_b++;
        end else begin
          lost_load = 1'b1;
        end
      end
      mec_pkg::OP_COMPARE: begin
        want_same.push_back(multisets_match());
        want_ovf.push_back(lost_load);
        fill_a    = 0;
        fill_b    = 0;
        lost_load = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic same, logic ovf);
    bit exp_same;
    bit exp_ovf;
    if (want_same.size() == 0) begin
      $display("%0t: result with nothing expected: same_elements=%b overflowed=%b",
               $time, same, ovf);
      errors++;
      return;
    end
    exp_same = want_same.pop_front();
    exp_ovf  = want_ovf.pop_front();
    if (same !== exp_same) begin
      $display("%0t: same_elements expected %b actual %b", $time, exp_same, same);
      errors++;
    end
    if (ovf !== exp_ovf) begin
      $display("%0t: overflowed expected %b actual %b", $time, exp_ovf, ovf);
      errors++;
    end
  endfunction

  function int pending();
    return want_same.size();
  endfunction
endclass

module tb_top;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [31:0] in_element;
  logic        out_valid;
  logic        out_ready;
  logic        out_same_elements;
  logic        out_overflowed;

  multiset_scoreboard sb;
  int  sent = 0;
  logic calm;

  // a stretch of requests where neither side idles
  assign calm = (sent >= 700) && (sent < 1000);

  always #5 clk = ~clk;

  multiset_equality_check_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_element        (in_element),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_same_elements (out_same_elements),
    .out_overflowed    (out_overflowed)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] opcode, logic [31:0] element);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= opcode;
    in_element <= element;
    do @(posedge clk); while (!in_ready);
    sb.note_request(opcode, element);
    if (opcode != OP_UNUSED) sent++;
    @(negedge clk);
  endtask

  // narrow values repeat a lot so duplicates get exercised
  function automatic logic [31:0] pick_value(bit wide);
    int r;
    if (wide) return $urandom;
    r = $urandom_range(7);
    if (r == 6) return 32'h8000_0000;
    if (r == 7) return 32'h7fff_ffff;
    return 32'(r - 3);
  endfunction

  task automatic load_and_compare(int len, bit make_equal, bit wide);
    logic [31:0] vals_a [$];
    logic [31:0] vals_b [$];
    logic [31:0] tmp;
    int          ia;
    int          ib;
    int          r;
    for (int k = 0; k < len; k++) vals_a.push_back(pick_value(wide));
    vals_b = vals_a;
    for (int k = vals_b.size() - 1; k > 0; k--) begin
      r         = $urandom_range(k);
      tmp       = vals_b[k];
      vals_b[k] = vals_b[r];
      vals_b[r] = tmp;
    end
    if (!make_equal) begin
      case ($urandom_range(2))
        0: begin
          if (vals_b.size() > 0) vals_b[$urandom_range(vals_b.size() - 1)] = pick_value(wide);
          else vals_b.push_back(pick_value(wide));
        end
        1: begin
          if (vals_b.size() > 0) void'(vals_b.pop_back());
          else vals_a.push_back(pick_value(wide));
        end
        default: vals_b.push_back(pick_value(wide));
      endcase
    end
    ia = 0;
    ib = 0;
    while (ia < vals_a.size() || ib < vals_b.size()) begin
      if ($urandom_range(99) < 3) send_request(OP_UNUSED, $urandom);
      if (ib >= vals_b.size() || (ia < vals_a.size() && $urandom_range(1) == 0)) begin
        send_request(mec_pkg::OP_LOAD_A, vals_a[ia]);
        ia++;
      end else begin
        send_request(mec_pkg::OP_LOAD_B, vals_b[ib]);
        ib++;
      end
    end
    send_request(mec_pkg::OP_COMPARE, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_same_elements, out_overflowed);
  end

  // receiver: random stalls plus two long hold-offs to back the block up
  initial begin
    int hold_left;
    bit held_first;
    bit held_second;
    hold_left   = 0;
    held_first  = 1'b0;
    held_second = 1'b0;
    out_ready   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && sent >= 300 && !held_first) begin
        held_first = 1'b1;
        hold_left  = 2500;
      end else if (hold_left == 0 && sent >= 1200 && !held_second) begin
        held_second = 1'b1;
        hold_left   = 2500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    int  round;
    int  big_runs;
    int  len;
    bit  make_equal;
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_opcode  = mec_pkg::OP_LOAD_A;
    in_element = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // two empty sequences
    send_request(mec_pkg::OP_COMPARE, 32'h0);
    // extremes of the element field
    send_request(mec_pkg::OP_LOAD_A, 32'h7fff_ffff);
    send_request(mec_pkg::OP_LOAD_B, 32'h8000_0000);
    send_request(mec_pkg::OP_COMPARE, 32'hffff_ffff);
    send_request(mec_pkg::OP_LOAD_A, 32'h8000_0000);
    send_request(mec_pkg::OP_LOAD_B, 32'h8000_0000);
    send_request(mec_pkg::OP_COMPARE, 32'h0);
    // duplicates in a different order
    send_request(mec_pkg::OP_LOAD_A, 32'hffff_ffff);
    send_request(mec_pkg::OP_LOAD_A, 32'hffff_ffff);
    send_request(mec_pkg::OP_LOAD_A, 32'h0);
    send_request(mec_pkg::OP_LOAD_B, 32'h0);
    send_request(mec_pkg::OP_LOAD_B, 32'hffff_ffff);
    send_request(mec_pkg::OP_LOAD_B, 32'hffff_ffff);
    send_request(mec_pkg::OP_COMPARE, 32'h0);
    // same values, different multiplicities
    send_request(mec_pkg::OP_LOAD_A, 32'd5);
    send_request(mec_pkg::OP_LOAD_A, 32'd5);
    send_request(mec_pkg::OP_LOAD_A, 32'd7);
    send_request(mec_pkg::OP_LOAD_B, 32'd5);
    send_request(mec_pkg::OP_LOAD_B, 32'd7);
    send_request(mec_pkg::OP_LOAD_B, 32'd7);
    send_request(mec_pkg::OP_COMPARE, 32'h0);
    // counts differ
    send_request(mec_pkg::OP_LOAD_A, 32'd1);
    send_request(mec_pkg::OP_COMPARE, 32'h0);
    // undefined opcode leaves state alone
    send_request(OP_UNUSED, 32'hffff_ffff);
    send_request(mec_pkg::OP_COMPARE, 32'h0);

    round    = 0;
    big_runs = 0;
    while (sent < 1650) begin
      make_equal = $urandom_range(99) < 60;
      if (round == 0) begin
        len        = mec_pkg::CAPACITY_DEF;
        make_equal = 1'b1;
        big_runs++;
      end else if (round == 1) begin
        len = mec_pkg::CAPACITY_DEF + 2;
        big_runs++;
      end else if (big_runs < 6 && $urandom_range(99) < 3) begin
        len = $urandom_range(mec_pkg::CAPACITY_DEF + 4, mec_pkg::CAPACITY_DEF - 8);
        big_runs++;
      end else begin
        len = $urandom_range(8);
      end
      load_and_compare(len, make_equal, $urandom_range(1));
      round++;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("multiset_equality_check_top regression: pass");
    end else begin
      $display("multiset_equality_check_top regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("multiset_equality_check_top regression: fail");
    $finish;
  end
endmodule
